>>> rtl/core/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 digest engine.
// No dependencies; used by every module in rtl/core.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
    logic [31:0] digest_word_5;
    logic [31:0] digest_word_6;
    logic [31:0] digest_word_7;
  } out_item_t;

  // Job handed from the packer to the compression core.
  typedef struct packed {
    logic [511:0] block;
    logic         last;
  } blk_job_t;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    PK_ACCEPT,
    PK_PAD,
    PK_LEN
  } pk_state_t;

  typedef enum logic [1:0] {
    CR_IDLE,
    CR_ROUND,
    CR_FOLD
  } cr_state_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LengthSlot = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/core/sha256_packer.sv
// Front end: packs bytes into 512-bit blocks, pads on end of message.
// Depends on sha256_pkg.
module sha256_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  sha256_pkg::in_item_t in_item,
  output logic                 job_valid,
  input  logic                 job_ready,
  output sha256_pkg::blk_job_t job
);

  sha256_pkg::pk_state_t state_r, state_nxt;
  logic [511:0] block_r, block_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  count_r, count_nxt;
  logic         job_valid_r, job_valid_nxt;
  sha256_pkg::blk_job_t job_r, job_nxt;

  logic accept;
  assign accept = in_push && !in_full;
  assign job_valid = job_valid_r;
  assign job = job_r;

  // Stall while a built block waits or padding is in progress.
  assign in_full = (state_r != sha256_pkg::PK_ACCEPT) || job_valid_r;

  function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] p,
                                       input logic [7:0] v);
    logic [511:0] o;
    o = b;
    o[511 - 8*p -: 8] = v;
    return o;
  endfunction

  // Zero every byte from slot p upward.
  function automatic logic [511:0] clr_from(input logic [511:0] b, input logic [5:0] p);
    logic [511:0] o;
    o = b;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) >= p) o[511 - 8*i -: 8] = 8'h00;
    end
    return o;
  endfunction

  always_comb begin
    logic [63:0] bits;
    state_nxt     = state_r;
    block_nxt     = block_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    bits          = count_r << 3;
    if (job_valid_r && job_ready) job_valid_nxt = 1'b0;
    unique case (state_r)
      sha256_pkg::PK_ACCEPT: begin
        if (accept) begin
          if (in_item.byte_present) begin
            block_nxt = put(block_r, pos_r, in_item.msg_byte);
            count_nxt = count_r + 64'd1;
            pos_nxt   = pos_r + 6'd1;
            if (pos_r == 6'd63) begin
              job_nxt       = '{block: block_nxt, last: 1'b0};
              job_valid_nxt = 1'b1;
            end
          end
          if (in_item.end_of_message) state_nxt = sha256_pkg::PK_PAD;
        end
      end
      sha256_pkg::PK_PAD: begin
        // Clear the tail, then append the marker; spill to an extra block if
        // no room is left for the length.
        if (!job_valid_r) begin
          block_nxt = put(clr_from(block_r, pos_r), pos_r, sha256_pkg::PadMark);
          if (pos_r >= sha256_pkg::LengthSlot) begin
            job_nxt       = '{block: block_nxt, last: 1'b0};
            job_valid_nxt = 1'b1;
            block_nxt     = '0;
          end
          state_nxt = sha256_pkg::PK_LEN;
        end
      end
      sha256_pkg::PK_LEN: begin
        if (!job_valid_r) begin
          job_nxt       = '{block: {block_r[511:64], bits}, last: 1'b1};
          job_valid_nxt = 1'b1;
          count_nxt     = '0;
          pos_nxt       = '0;
          state_nxt     = sha256_pkg::PK_ACCEPT;
        end
      end
      default: state_nxt = sha256_pkg::PK_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::PK_ACCEPT;
      pos_r       <= '0;
      count_r     <= '0;
      job_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      job_valid_r <= job_valid_nxt;
    end
    block_r <= block_nxt;
    job_r   <= job_nxt;
  end

endmodule

>>> rtl/core/sha256_queue.sv
// Short job queue between packer and compression core.
// Depends on sha256_pkg.
module sha256_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  sha256_pkg::blk_job_t wr_job,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output sha256_pkg::blk_job_t rd_job
);

  sha256_pkg::blk_job_t slot_r [sha256_pkg::QueueDepth];
  logic [$clog2(sha256_pkg::QueueDepth)-1:0] wp_r, rp_r;
  logic [$clog2(sha256_pkg::QueueDepth):0]   cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'(sha256_pkg::QueueDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_job   = slot_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) slot_r[wp_r] <= wr_job;
  end

endmodule

>>> rtl/core/sha256_core.sv
// Back end: 64-round compression, one round per cycle, plus digest register.
// Depends on sha256_pkg.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  sha256_pkg::blk_job_t  job,
  output logic                  out_empty,
  input  logic                  out_pop,
  output sha256_pkg::out_item_t out_item
);

  sha256_pkg::cr_state_t state_r, state_nxt;
  logic [255:0] chain_r, chain_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  v_r [8];
  logic [5:0]   rnd_r;
  logic         last_r;
  logic         out_valid_r;
  logic [255:0] digest_r;

  logic [31:0] w_cur, w_new, t1, t2, s0, s1;
  logic [255:0] folded;
  logic        fold_go;

  assign out_empty = !out_valid_r;
  assign out_item  = digest_r;
  assign job_ready = (state_r == sha256_pkg::CR_IDLE);
  // Hold a final fold only while the previous digest still waits.
  assign fold_go = (state_r == sha256_pkg::CR_FOLD) && (!last_r || !out_valid_r || out_pop);

  always_comb begin
    s0 = sha256_pkg::rotr(w_r[1], 7) ^ sha256_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha256_pkg::rotr(w_r[14], 17) ^ sha256_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    w_cur = (rnd_r < 6'd16) ? w_r[0] : w_new;
    t1 = v_r[7] + (sha256_pkg::rotr(v_r[4], 6) ^ sha256_pkg::rotr(v_r[4], 11)
         ^ sha256_pkg::rotr(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha256_pkg::round_k(rnd_r) + w_cur;
    t2 = (sha256_pkg::rotr(v_r[0], 2) ^ sha256_pkg::rotr(v_r[0], 13)
         ^ sha256_pkg::rotr(v_r[0], 22)) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2])
         ^ (v_r[1] & v_r[2]));
    for (int i = 0; i < 8; i++) begin
      folded[255 - 32*i -: 32] = chain_r[255 - 32*i -: 32] + v_r[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    chain_nxt = chain_r;
    unique case (state_r)
      sha256_pkg::CR_IDLE: if (job_valid && job_ready) state_nxt = sha256_pkg::CR_ROUND;
      sha256_pkg::CR_ROUND: if (rnd_r == 6'd63) state_nxt = sha256_pkg::CR_FOLD;
      sha256_pkg::CR_FOLD: begin
        if (fold_go) begin
          chain_nxt = last_r ? sha256_pkg::InitHash : folded;
          state_nxt = sha256_pkg::CR_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::CR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::CR_IDLE;
      chain_r     <= sha256_pkg::InitHash;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      if (fold_go && last_r) out_valid_r <= 1'b1;
    end
    if (fold_go && last_r) digest_r <= folded;
    if (state_r == sha256_pkg::CR_IDLE) begin
      rnd_r  <= '0;
      last_r <= job.last;
      for (int i = 0; i < 16; i++) w_r[i] <= job.block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++)  v_r[i] <= chain_r[255 - 32*i -: 32];
    end else if (state_r == sha256_pkg::CR_ROUND) begin
      rnd_r <= rnd_r + 6'd1;
      // Shift the schedule window; the word just used moves to the tail.
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

endmodule

>>> rtl/core/sha256_digest_engine.sv
// Top level of the SHA-256 digest engine: packer, job queue, compression core.
// In the core, each block is loaded, run through the rounds and folded into the chain.
// Throughput: one byte per cycle into the packer, except that input stalls while a
// finished block waits for the queue and while padding; the core compresses queued
// blocks back to back and sets the sustained rate; end of message adds one or two
// padded blocks, and a final fold waits while an earlier digest is unread.
// Synchronous active-low reset restores the initial hash values and clears
// byte count, fill position, the job queue and the digest-valid flag.
module sha256_digest_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output sha256_pkg::out_item_t out_item
);

  logic pk_valid, pk_ready, q_valid, q_ready;
  sha256_pkg::blk_job_t pk_job, q_job;

  // Front: accept bytes, build and pad blocks.
  sha256_packer u_packer (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .job_valid(pk_valid), .job_ready(pk_ready), .job(pk_job)
  );

  // Hold up to two blocks so the packer keeps taking bytes during rounds.
  sha256_queue u_queue (
    .clk, .rst_n,
    .wr_valid(pk_valid), .wr_ready(pk_ready), .wr_job(pk_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
  );

  // Back: compress, fold into chain, present the digest transaction.
  sha256_core u_core (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_empty, .out_pop, .out_item
  );

endmodule

>>> tb/sha256_digest_checker.sv
`timescale 1ns / 1ps
// Checker for the SHA-256 digest engine: watches input and digest transactions,
// predicts digests with its own SHA-256 model and compares. Depends on sha256_pkg.
module sha256_digest_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  sha256_pkg::in_item_t  in_item,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  sha256_pkg::out_item_t out_item,
  output int                    fail_count,
  output int                    pending_digests
);

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [255:0] hash_state;
  logic [511:0] msg_block;
  logic [63:0]  byte_total;
  logic [5:0]   fill_slot;
  sha256_pkg::out_item_t digest_q[$];

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Fold one 512-bit block into the hash state.
  function automatic logic [255:0] sha_fold(logic [255:0] h, logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    logic [255:0] res;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = h[255 - 32*i -: 32];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = h[255 - 32*i -: 32] + v[i];
    return res;
  endfunction

  task automatic absorb_item(sha256_pkg::in_item_t it);
    logic [63:0] bit_len;
    int pos;
    if (it.byte_present) begin
      msg_block[511 - 8*fill_slot -: 8] = it.msg_byte;
      byte_total++;
      fill_slot++;
      if (fill_slot == 0) hash_state = sha_fold(hash_state, msg_block);
    end
    if (!it.end_of_message) return;
    bit_len = byte_total << 3;
    pos = fill_slot;
    msg_block[511 - 8*pos -: 8] = sha256_pkg::PadMark;
    pos++;
    if (pos > 56) begin
      for (; pos < 64; pos++) msg_block[511 - 8*pos -: 8] = 8'h00;
      hash_state = sha_fold(hash_state, msg_block);
      pos = 0;
    end
    for (; pos < 56; pos++) msg_block[511 - 8*pos -: 8] = 8'h00;
    msg_block[63:0] = bit_len;
    hash_state = sha_fold(hash_state, msg_block);
    digest_q.push_back(sha256_pkg::out_item_t'(hash_state));
    hash_state = sha256_pkg::InitHash;
    byte_total = '0;
    fill_slot = '0;
  endtask

  assign pending_digests = digest_q.size();

  always @(posedge clk) begin
    sha256_pkg::out_item_t want;
    if (!rst_n) begin
      hash_state = sha256_pkg::InitHash;
      byte_total = '0;
      fill_slot = '0;
      msg_block = '0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (in_push && !in_full) absorb_item(in_item);
      if (out_pop && !out_empty) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected digest %h", out_item);
        end else begin
          want = digest_q.pop_front();
          if (want !== out_item) begin
            fail_count++;
            if (fail_count <= 10) $display("digest mismatch: exp %h got %h", want, out_item);
          end
        end
      end
    end
  end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the SHA-256 digest engine: clock, reset, byte stimulus and verdict.
// Depends on sha256_pkg, sha256_digest_engine and sha256_digest_checker.
module tb_top;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  sha256_pkg::in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  sha256_pkg::out_item_t out_item;
  int        fail_count;
  int        pending_digests;
  int        items_sent = 0;
  bit        calm_phase = 1'b0;  // no idling on either side near the end
  int        hold_cycles = 0;    // long receiver hold-off, counted below

  always #5 clk = ~clk;

  sha256_digest_engine u_top (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item));

  sha256_digest_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .fail_count(fail_count), .pending_digests(pending_digests));

  // Offer one transaction, with an optional random idle burst first; hold until accepted.
  task automatic send_item(logic [7:0] b, logic present, logic last);
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{msg_byte: b, byte_present: present, end_of_message: last};
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  // Send a whole message: len bytes, end flag either on the last byte or alone.
  task automatic send_message(int len, bit end_alone);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
    if (len == 0 || end_alone) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stall bursts, and one long hold-off so digests back up.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        hold_cycles--;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    int lens[] = '{0, 1, 3, 55, 56, 57, 63, 64, 65};
    int drain;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: boundary lengths around the padding split, end with or without a byte.
    send_item(8'h00, 1'b0, 1'b0);  // idle item, does nothing
    send_item(8'hff, 1'b1, 1'b1);  // single 0xff byte message
    foreach (lens[i]) send_message(lens[i], i % 2);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);  // end alone after a zero byte

    // Hold the receiver off long enough that digests pile up and the input stalls.
    hold_cycles = 3000;
    for (int m = 0; m < 12; m++) send_message($urandom_range(0, 8), $urandom_range(0, 1));

    // Random: mostly well-formed messages, some noise items mixed in.
    while (items_sent < 450) begin
      if (items_sent > 380) calm_phase = 1'b1;
      if ($urandom_range(0, 7) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      else if ($urandom_range(0, 9) == 0)
        send_message($urandom_range(50, 130), $urandom_range(0, 1));
      else
        send_message($urandom_range(0, 12), $urandom_range(0, 1));
    end
    in_push <= 1'b0;

    // Drain: wait for every expected digest, then a tail for the core latency.
    drain = 0;
    while (pending_digests != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_digests == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
